// ===== rtl/core/brmd_pkg.sv =====
package brmd_pkg;

    localparam int TARGET_WIDTH = 32;
    localparam int NUM_WIDTH    = 21;

    typedef struct packed {
        logic load;
        logic gen;
        logic mul;
        logic cmp;
        logic publish;
    } t_cmd;

    typedef struct packed {
        logic zero_max;
        logic last;
    } t_status;

endpackage

// ===== rtl/core/brmd_ctrl.sv =====
module brmd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    output logic              o_valid,
    input  logic              i_stall,
    output brmd_pkg::t_cmd    o_cmd,
    input  brmd_pkg::t_status i_sts
);
    import brmd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_GEN,
        S_MUL,
        S_CMP,
        S_DONE
    } t_state;

    t_state r_state;
    logic   r_out_valid;

    always_comb begin
        o_cmd         = '0;
        o_cmd.load    = (r_state == S_IDLE) && i_valid;
        o_cmd.gen     = (r_state == S_GEN) || ((r_state == S_CMP) && !i_sts.last);
        o_cmd.mul     = (r_state == S_MUL);
        o_cmd.cmp     = (r_state == S_CMP);
        o_cmd.publish = (r_state == S_DONE) && (!r_out_valid || !i_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.publish) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_state <= i_sts.zero_max ? S_DONE : S_GEN;
                    end
                end
                S_GEN: begin
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    r_state <= i_sts.last ? S_DONE : S_MUL;
                end
                S_DONE: begin
                    if (o_cmd.publish) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;

endmodule

// ===== rtl/core/brmd_dp.sv =====
module brmd_dp #(
    parameter int FRACTION_BITS = 24,
    parameter int DENOM_BITS    = 12
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_cfg_we,
    input  logic [DENOM_BITS-1:0]                      i_cfg_wdata,
    input  logic signed [brmd_pkg::TARGET_WIDTH-1:0]   i_target_value,
    input  brmd_pkg::t_cmd                             i_cmd,
    output brmd_pkg::t_status                          o_sts,
    output logic signed [brmd_pkg::NUM_WIDTH-1:0]      o_best_numerator,
    output logic [DENOM_BITS-1:0]                      o_best_denominator
);
    import brmd_pkg::*;

    localparam int XW  = TARGET_WIDTH + DENOM_BITS + 1;
    localparam int NW  = XW - FRACTION_BITS;
    localparam int EW  = FRACTION_BITS + 1;
    localparam int BEW = TARGET_WIDTH;
    localparam int PW  = TARGET_WIDTH + DENOM_BITS;
    localparam int LW  = EW + DENOM_BITS;
    localparam int SW  = (NW > NUM_WIDTH) ? NW : NUM_WIDTH;

    localparam logic [XW-1:0] HALF_X = XW'(1) << (FRACTION_BITS - 1);
    localparam logic [EW-1:0] HALF_E = EW'(1) << (FRACTION_BITS - 1);
    localparam logic [EW-1:0] ONE_E  = EW'(1) << FRACTION_BITS;
    localparam logic signed [SW-1:0] SAT_HI = SW'((1 <<< (NUM_WIDTH - 1)) - 1);
    localparam logic signed [SW-1:0] SAT_LO = SW'(-(1 <<< (NUM_WIDTH - 1)));

    logic [DENOM_BITS-1:0]          r_max;
    logic signed [TARGET_WIDTH-1:0] r_t;
    logic signed [XW-1:0]           r_x;
    logic [DENOM_BITS-1:0]          r_cd;
    logic [EW-1:0]                  r_e;
    logic signed [NW-1:0]           r_n;
    logic [DENOM_BITS-1:0]          r_ed;
    logic [PW-1:0]                  r_lhs;
    logic [PW-1:0]                  r_rhs;
    logic signed [NW-1:0]           r_best_n;
    logic [DENOM_BITS-1:0]          r_best_d;
    logic [BEW-1:0]                 r_best_e;
    logic signed [NUM_WIDTH-1:0]    r_out_num;
    logic [DENOM_BITS-1:0]          r_out_den;

    logic [TARGET_WIDTH-1:0]   w_abs_t;
    logic [FRACTION_BITS-1:0]  w_low;
    logic [EW-1:0]             w_low_e;
    logic                      w_neg;
    logic                      w_low_nz;
    logic signed [NW-1:0]      w_n;
    logic [EW-1:0]             w_e;
    logic [LW-1:0]             w_lhs_p;
    logic [PW-1:0]             w_rhs_p;
    logic signed [SW-1:0]      w_bn_ext;
    logic signed [NUM_WIDTH-1:0] w_sat;

    assign w_abs_t  = i_target_value[TARGET_WIDTH-1] ?
                      (~i_target_value + TARGET_WIDTH'(1)) : i_target_value;

    // candidate numerator and error from d*t + half
    assign w_low    = r_x[FRACTION_BITS-1:0];
    assign w_low_e  = {1'b0, w_low};
    assign w_neg    = r_x[XW-1];
    assign w_low_nz = |w_low;
    assign w_n      = $signed(r_x[XW-1:FRACTION_BITS])
                    + $signed({{(NW-1){1'b0}}, w_neg & w_low_nz});

    always_comb begin
        if (!w_neg) begin
            w_e = (w_low_e >= HALF_E) ? (w_low_e - HALF_E) : (HALF_E - w_low_e);
        end else if (!w_low_nz) begin
            w_e = HALF_E;
        end else begin
            w_e = ONE_E - w_low_e + HALF_E;
        end
    end

    // cross products of candidate error and best error
    assign w_lhs_p = r_e * r_best_d;
    assign w_rhs_p = r_best_e * r_ed;

    assign w_bn_ext = SW'(r_best_n);
    always_comb begin
        if (w_bn_ext > SAT_HI) begin
            w_sat = SAT_HI[NUM_WIDTH-1:0];
        end else if (w_bn_ext < SAT_LO) begin
            w_sat = SAT_LO[NUM_WIDTH-1:0];
        end else begin
            w_sat = w_bn_ext[NUM_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= DENOM_BITS'(255);
        end else if (i_cfg_we) begin
            r_max <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_t      <= i_target_value;
            r_x      <= XW'(i_target_value) + $signed(HALF_X);
            r_cd     <= DENOM_BITS'(1);
            r_best_n <= '0;
            r_best_d <= DENOM_BITS'(1);
            r_best_e <= w_abs_t;
        end else begin
            if (i_cmd.gen) begin
                r_e  <= w_e;
                r_n  <= w_n;
                r_ed <= r_cd;
                r_x  <= r_x + XW'(r_t);
                r_cd <= r_cd + DENOM_BITS'(1);
            end
            if (i_cmd.cmp && (r_lhs < r_rhs)) begin
                r_best_n <= r_n;
                r_best_d <= r_ed;
                r_best_e <= BEW'(r_e);
            end
        end
        if (i_cmd.mul) begin
            r_lhs <= PW'(w_lhs_p);
            r_rhs <= w_rhs_p;
        end
        if (i_cmd.publish) begin
            r_out_num <= w_sat;
            r_out_den <= r_best_d;
        end
    end

    assign o_sts.zero_max     = (r_max == '0);
    assign o_sts.last         = (r_ed == r_max);
    assign o_best_numerator   = r_out_num;
    assign o_best_denominator = r_out_den;

endmodule

// ===== rtl/core/best_rational_max_denominator.sv =====
// Finds the fraction n/d closest to a signed fixed-point target (FRACTION_BITS
// fraction bits) over every denominator from 1 to max_denominator, starting
// from 0/1; ties keep the smaller denominator and the numerator output
// saturates to 21 bits; max_denominator resets to 255. The result register is
// loaded once the search ends, and the next item is accepted only after that
// load, so the block never works on two items at once: each denominator
// passes through the pair of cross-product multipliers and then the
// compare-and-update of the running best, with the next candidate's numerator
// and error formed alongside the compare. A max_denominator of zero skips the
// search and loads 0/1. The result register lets the next item be accepted
// while a result still waits to be taken; a finished item waits in the block
// until that register is free.
module best_rational_max_denominator #(
    parameter int FRACTION_BITS = 24,
    parameter int DENOM_BITS    = 12
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_cfg_we,
    input  logic [DENOM_BITS-1:0]                    i_cfg_wdata,
    input  logic                                     i_valid,
    output logic                                     o_stall,
    input  logic signed [brmd_pkg::TARGET_WIDTH-1:0] i_target_value,
    output logic                                     o_valid,
    input  logic                                     i_stall,
    output logic signed [brmd_pkg::NUM_WIDTH-1:0]    o_best_numerator,
    output logic [DENOM_BITS-1:0]                    o_best_denominator
);
    import brmd_pkg::*;

    t_cmd    w_cmd;
    t_status w_sts;

    brmd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (w_cmd),
        .i_sts   (w_sts)
    );

    brmd_dp #(
        .FRACTION_BITS (FRACTION_BITS),
        .DENOM_BITS    (DENOM_BITS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_target_value     (i_target_value),
        .i_cmd              (w_cmd),
        .o_sts              (w_sts),
        .o_best_numerator   (o_best_numerator),
        .o_best_denominator (o_best_denominator)
    );

endmodule

// ===== rtl/core/brmd_checker.sv =====
module brmd_checker #(
    parameter int DENOM_BITS = 12
) (
    input logic                                     i_clk,
    input logic                                     i_rst_n,
    input logic                                     i_valid,
    input logic                                     o_stall,
    input logic                                     o_valid,
    input logic                                     i_stall,
    input logic signed [brmd_pkg::NUM_WIDTH-1:0]    o_best_numerator,
    input logic [DENOM_BITS-1:0]                    o_best_denominator
);
    import brmd_pkg::*;

    // an accepted item keeps the block busy on the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("block took a second item right after the first");

    // a new result appears only at the end of a busy stretch
    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result appeared without a busy stretch");

    // no result can be ready in the cycle after an item is taken
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> !$rose(o_valid))
        else $error("result appeared one cycle after the item");

    // a denominator is never zero
    a_denom_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_best_denominator != '0))
        else $error("zero denominator delivered");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_best_numerator)
                                  && $stable(o_best_denominator)))
        else $error("stalled result changed");

endmodule

bind best_rational_max_denominator brmd_checker #(
    .DENOM_BITS (DENOM_BITS)
) u_brmd_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_valid            (i_valid),
    .o_stall            (o_stall),
    .o_valid            (o_valid),
    .i_stall            (i_stall),
    .o_best_numerator   (o_best_numerator),
    .o_best_denominator (o_best_denominator)
);
